/* hw/rtl/signed_int_to_decimal_ascii_macros.svh */
// Assertion macros for the decimal ASCII converter.
`ifndef SIGNED_INT_TO_DECIMAL_ASCII_MACROS_SVH
`define SIGNED_INT_TO_DECIMAL_ASCII_MACROS_SVH

`ifndef ASSERT_OFF
`define SIDA_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("implication check failed");
`define SIDA_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("next-cycle check failed");
`else
`define SIDA_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define SIDA_ASSERT_NXT(lbl, clk, rstn, ante, cons)
`endif

`endif

/* hw/rtl/sida_pkg.sv */
// Shared constants and types for the decimal ASCII converter.
package sida_pkg;

  localparam int VALUE_WIDTH = 32;
  localparam int PROD_W      = 2 * VALUE_WIDTH;
  localparam int MAX_DIGITS  = 10;
  localparam int DIGIT_IDX_W = $clog2(MAX_DIGITS);
  localparam int DIGIT_W     = 4;
  localparam int CHAR_W      = 7;
  localparam int TDATA_OUT_W = 8;

  localparam logic [CHAR_W-1:0] ASCII_ZERO  = 7'h30;
  localparam logic [CHAR_W-1:0] ASCII_MINUS = 7'h2D;

  // q = (x * DIV10_RECIP) >> DIV10_SHIFT equals x / 10 for all 32-bit x
  localparam logic [VALUE_WIDTH-1:0] DIV10_RECIP = 32'hCCCC_CCCD;
  localparam int                     DIV10_SHIFT = 35;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef struct packed {
    logic                   neg;
    logic [VALUE_WIDTH-1:0] mag;
  } item_t;

endpackage

/* hw/rtl/signed_int_to_decimal_ascii.sv */
// Top level: signed integer to decimal ASCII text stream.
//
//   channel | dir | tdata (low bit up)      | tlast          | request
//   in_     | in  | value[31:0]             | -              | one integer
//   out_    | out | character[6:0], 1'b0   | last character | one character
//
// Front stage registers a request and hands it to a two-entry queue. The
// digit engine leaves its idle state, runs a multiply and a remainder step
// per decimal digit, then emits the characters, a leading '-' first for a
// negative value. The output register holds a stalled character; the front
// keeps taking requests until the queue fills. Synchronous reset clears all
// control state.
`include "signed_int_to_decimal_ascii_macros.svh"

module signed_int_to_decimal_ascii (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [sida_pkg::VALUE_WIDTH-1:0]    in_tdata,   // value[31:0]
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [sida_pkg::TDATA_OUT_W-1:0]    out_tdata,  // character[6:0], pad[7]
  output logic                                out_tlast
);

  logic            push_valid;
  logic            push_ready;
  sida_pkg::item_t push_item;
  logic            pop_valid;
  logic            pop_ready;
  sida_pkg::item_t pop_item;
  logic            out_is_minus;
  logic            out_is_digit;

  sida_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item)
  );

  sida_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_item   (pop_item)
  );

  sida_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_item   (pop_item),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  assign out_is_minus = out_tdata == {1'b0, sida_pkg::ASCII_MINUS};
  assign out_is_digit = (out_tdata >= {1'b0, sida_pkg::ASCII_ZERO}) &&
                        (out_tdata <= ({1'b0, sida_pkg::ASCII_ZERO} + 8'd9));

  `SIDA_ASSERT_IMP(a_minus_not_last, clk, rst_n, out_tvalid && out_is_minus, !out_tlast)
  `SIDA_ASSERT_IMP(a_char_legal, clk, rst_n, out_tvalid, out_is_minus || out_is_digit)
  `SIDA_ASSERT_NXT(a_text_unbroken, clk, rst_n, out_tvalid && out_tready && !out_tlast, out_tvalid)

endmodule

/* hw/rtl/sida_front.sv */
// Front stage: takes requests, splits sign and magnitude.
module sida_front (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [sida_pkg::VALUE_WIDTH-1:0]  in_tdata,
  output logic                              push_valid,
  input  logic                              push_ready,
  output sida_pkg::item_t                   push_item
);

  logic            valid_r;
  sida_pkg::item_t item_r;
  sida_pkg::item_t item_nxt;
  logic            take;

  assign in_tready  = !valid_r || push_ready;
  assign take       = in_tvalid && in_tready;
  assign push_valid = valid_r;
  assign push_item  = item_r;

  always_comb begin
    item_nxt.neg = in_tdata[sida_pkg::VALUE_WIDTH-1];
    item_nxt.mag = item_nxt.neg ? (~in_tdata + 1'b1) : in_tdata;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (take) begin
      valid_r <= 1'b1;
    end else if (push_ready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      item_r <= item_nxt;
    end
  end

endmodule

/* hw/rtl/sida_queue.sv */
// Short queue between the front stage and the digit engine.
module sida_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push_valid,
  output logic            push_ready,
  input  sida_pkg::item_t push_item,
  output logic            pop_valid,
  input  logic            pop_ready,
  output sida_pkg::item_t pop_item
);

  sida_pkg::item_t                  entries_r [sida_pkg::QUEUE_DEPTH];
  logic [sida_pkg::QPTR_W-1:0]      wptr_r;
  logic [sida_pkg::QPTR_W-1:0]      rptr_r;
  logic [sida_pkg::QCNT_W-1:0]      cnt_r;
  logic                             do_push;
  logic                             do_pop;

  assign push_ready = cnt_r != sida_pkg::QCNT_W'(sida_pkg::QUEUE_DEPTH);
  assign pop_valid  = cnt_r != '0;
  assign pop_item   = entries_r[rptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  function automatic logic [sida_pkg::QPTR_W-1:0] wrap_inc(
    input logic [sida_pkg::QPTR_W-1:0] p
  );
    if (p == sida_pkg::QPTR_W'(sida_pkg::QUEUE_DEPTH - 1)) begin
      return '0;
    end
    return p + 1'b1;
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      if (do_push) begin
        wptr_r <= wrap_inc(wptr_r);
      end
      if (do_pop) begin
        rptr_r <= wrap_inc(rptr_r);
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries_r[wptr_r] <= push_item;
    end
  end

endmodule

/* hw/rtl/sida_back.sv */
// Digit engine: divides by ten per digit, then emits a '-' for negatives and the digits MSD first.
module sida_back (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               pop_valid,
  output logic                               pop_ready,
  input  sida_pkg::item_t                    pop_item,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [sida_pkg::TDATA_OUT_W-1:0]   out_tdata,
  output logic                               out_tlast
);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_MUL  = 4'b0010,
    ST_REM  = 4'b0100,
    ST_EMIT = 4'b1000
  } bst_t;

  bst_t                                   state_r, state_nxt;
  logic [sida_pkg::VALUE_WIDTH-1:0]       mag_r, mag_nxt;
  logic [sida_pkg::PROD_W-1:0]            prod_r, prod_nxt;
  logic                                   neg_r, neg_nxt;
  logic [sida_pkg::DIGIT_W-1:0]           digits_r [sida_pkg::MAX_DIGITS];
  logic [sida_pkg::DIGIT_IDX_W-1:0]       dp_r, dp_nxt;
  logic                                   dig_we;
  logic [sida_pkg::DIGIT_W-1:0]           dig_wdata;
  logic                                   ovalid_r, ovalid_nxt;
  logic [sida_pkg::CHAR_W-1:0]            ochar_r, ochar_nxt;
  logic                                   olast_r, olast_nxt;
  logic                                   oload;
  logic                                   slot_free;
  logic [sida_pkg::VALUE_WIDTH-1:0]       quo;
  logic [sida_pkg::VALUE_WIDTH-1:0]       quo10;
  logic [sida_pkg::VALUE_WIDTH-1:0]       rem_full;

  assign slot_free  = !ovalid_r || out_tready;
  assign out_tvalid = ovalid_r;
  assign out_tdata  = {1'b0, ochar_r};
  assign out_tlast  = olast_r;
  assign pop_ready  = state_r == ST_IDLE;

  assign quo      = sida_pkg::VALUE_WIDTH'(prod_r >> sida_pkg::DIV10_SHIFT);
  assign quo10    = (quo << 3) + (quo << 1);
  assign rem_full = mag_r - quo10;

  always_comb begin
    state_nxt  = state_r;
    mag_nxt    = mag_r;
    prod_nxt   = prod_r;
    neg_nxt    = neg_r;
    dp_nxt     = dp_r;
    dig_we     = 1'b0;
    dig_wdata  = rem_full[sida_pkg::DIGIT_W-1:0];
    oload      = 1'b0;
    ochar_nxt  = ochar_r;
    olast_nxt  = olast_r;
    unique case (state_r)
      ST_IDLE: begin
        if (pop_valid) begin
          mag_nxt   = pop_item.mag;
          neg_nxt   = pop_item.neg && (pop_item.mag != '0);
          dp_nxt    = '0;
          state_nxt = ST_MUL;
        end
      end
      ST_MUL: begin
        prod_nxt  = sida_pkg::PROD_W'(mag_r) * sida_pkg::PROD_W'(sida_pkg::DIV10_RECIP);
        state_nxt = ST_REM;
      end
      ST_REM: begin
        dig_we  = 1'b1;
        mag_nxt = quo;
        if (quo == '0) begin
          state_nxt = ST_EMIT;
        end else begin
          dp_nxt    = dp_r + 1'b1;
          state_nxt = ST_MUL;
        end
      end
      ST_EMIT: begin
        if (slot_free) begin
          oload = 1'b1;
          if (neg_r) begin
            ochar_nxt = sida_pkg::ASCII_MINUS;
            olast_nxt = 1'b0;
            neg_nxt   = 1'b0;
          end else begin
            ochar_nxt = sida_pkg::ASCII_ZERO + sida_pkg::CHAR_W'(digits_r[dp_r]);
            olast_nxt = dp_r == '0;
            if (dp_r == '0) begin
              state_nxt = ST_IDLE;
            end else begin
              dp_nxt = dp_r - 1'b1;
            end
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    if (oload) begin
      ovalid_nxt = 1'b1;
    end else if (out_tready) begin
      ovalid_nxt = 1'b0;
    end else begin
      ovalid_nxt = ovalid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      ovalid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      ovalid_r <= ovalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mag_r   <= mag_nxt;
    prod_r  <= prod_nxt;
    neg_r   <= neg_nxt;
    dp_r    <= dp_nxt;
    ochar_r <= ochar_nxt;
    olast_r <= olast_nxt;
    if (dig_we) begin
      digits_r[dp_r] <= dig_wdata;
    end
  end

endmodule
